FILE: rtl/multi_channel_task_watchdog_core_macros.svh
// Assertion macros used by the watchdog core file.
`ifndef MULTI_CHANNEL_TASK_WATCHDOG_CORE_MACROS_SVH
`define MULTI_CHANNEL_TASK_WATCHDOG_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MCTW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MCTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mctw_pkg.sv
// Types and constants of the multi-channel task watchdog.
package mctw_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TIME_W       = 32;
  localparam int CNT_W        = 4;

  localparam logic [CNT_W-1:0]  CNT_MAX       = 4'd15;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;
  localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(NUM_CHANNELS - 1);

  typedef enum logic [2:0] {
    ACT_CLEAR    = 3'd0,
    ACT_START    = 3'd1,
    ACT_FEED     = 3'd2,
    ACT_STOP     = 3'd3,
    ACT_CHECK    = 3'd4,
    ACT_BOOKKEEP = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [2:0]        channel;
    logic [TIME_W-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] expired_count;
    logic             panic;
    logic             refresh;
  } result_t;

endpackage

FILE: rtl/mctw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mctw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/multi_channel_task_watchdog_core.sv
// Top level of the multi-channel task watchdog: channel flags, feed-time RAM, scan engine.
//
//   port group          dir  transfer when          contents
//   start/busy/cmd      in   start && !busy         action, channel, now_ms
//   done/result         out  done (one cycle)       expired_count, panic, refresh
//   cfg_we/cfg_wdata    in   cfg_we                 timeout_ms
//
// Clear all, start, feed and stop complete without raising busy.
// Check and bookkeep walk the feed-time RAM one channel per cycle: busy stays
// high through the scan, wait and done states, and done pulses in the cycle after
// the done state; the single RAM read port sets the one-channel rate.
// Reset (rst, synchronous) stops every channel and loads timeout_ms = 1000.
// Results cannot be stalled; each is shown for exactly one cycle.
`include "multi_channel_task_watchdog_core_macros.svh"

module multi_channel_task_watchdog_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  mctw_pkg::cmd_t                cmd,
  output logic                          done,
  output mctw_pkg::result_t             result,
  input  logic                          cfg_we,
  input  logic [mctw_pkg::TIME_W-1:0]   cfg_wdata
);

  mctw_pkg::state_t                  state;
  mctw_pkg::state_t                  state_next;
  mctw_pkg::action_t                 act;
  logic [mctw_pkg::TIME_W-1:0]       timeout;
  logic [mctw_pkg::NUM_CHANNELS-1:0] active;
  logic                              accept;
  logic                              ch_ok;
  logic [mctw_pkg::ADDR_W-1:0]       ch_addr;
  logic                              scan_go;
  logic                              wr_en;
  logic                              rd_en;
  logic [mctw_pkg::ADDR_W-1:0]       rd_idx;
  logic                              rd_vld;
  logic [mctw_pkg::ADDR_W-1:0]       rd_tag;
  logic [mctw_pkg::TIME_W-1:0]       rdata;
  logic [mctw_pkg::TIME_W-1:0]       now_q;
  logic [mctw_pkg::TIME_W-1:0]       elapsed;
  logic                              is_check;
  logic                              hit;
  logic [mctw_pkg::CNT_W-1:0]        cnt;

  // Decode the incoming command
  assign busy    = (state != mctw_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign act     = mctw_pkg::action_t'(cmd.action);
  assign ch_ok   = (32'(cmd.channel) < 32'(mctw_pkg::NUM_CHANNELS));
  assign ch_addr = mctw_pkg::ADDR_W'(cmd.channel);
  assign scan_go = accept && (act inside {mctw_pkg::ACT_CHECK, mctw_pkg::ACT_BOOKKEEP});
  assign wr_en   = accept && ch_ok &&
                   (act inside {mctw_pkg::ACT_START, mctw_pkg::ACT_FEED});

  // Feed times; a stopped channel's time is read but never counted
  mctw_ram #(
    .WIDTH (mctw_pkg::TIME_W),
    .DEPTH (mctw_pkg::NUM_CHANNELS)
  ) u_feed_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ch_addr),
    .wdata (cmd.now_ms),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  // Compare the returned feed time against the timeout
  assign elapsed = now_q - rdata;
  assign hit     = rd_vld && active[rd_tag] && (elapsed > timeout);

  // Next state and read issue
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    case (state)
      mctw_pkg::S_IDLE: begin
        if (scan_go) begin
          state_next = mctw_pkg::S_SCAN;
        end
      end
      mctw_pkg::S_SCAN: begin
        rd_en = 1'b1;
        if (rd_idx == mctw_pkg::LAST_ADDR) begin
          state_next = mctw_pkg::S_WAIT;
        end
      end
      mctw_pkg::S_WAIT: begin
        state_next = mctw_pkg::S_DONE;
      end
      mctw_pkg::S_DONE: begin
        state_next = mctw_pkg::S_IDLE;
      end
      default: begin
        state_next = mctw_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers, channel flags and timeout
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mctw_pkg::S_IDLE;
      rd_vld  <= 1'b0;
      done    <= 1'b0;
      timeout <= mctw_pkg::TIMEOUT_RESET;
      active  <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      done   <= (state == mctw_pkg::S_DONE);
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
      if (accept) begin
        case (act)
          mctw_pkg::ACT_CLEAR: begin
            active <= '0;
          end
          mctw_pkg::ACT_START: begin
            if (ch_ok) begin
              active[ch_addr] <= 1'b1;
            end
          end
          mctw_pkg::ACT_STOP: begin
            if (ch_ok) begin
              active[ch_addr] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Scan payload: latch the command, advance the read index, count hits
  always_ff @(posedge clk) begin
    rd_tag <= rd_idx;
    if (scan_go) begin
      now_q    <= cmd.now_ms;
      is_check <= (act == mctw_pkg::ACT_CHECK);
      rd_idx   <= '0;
      cnt      <= '0;
    end else begin
      if (rd_en) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (hit && (cnt != mctw_pkg::CNT_MAX)) begin
        cnt <= cnt + 1'b1;
      end
    end
    if (state == mctw_pkg::S_DONE) begin
      result.expired_count <= cnt;
      result.panic         <= is_check && (cnt != '0);
      result.refresh       <= is_check && (cnt == '0);
    end
  end

  // Checks
  `MCTW_ASSERT_NEXT(a_scan_busy, clk, rst, scan_go, busy, "scan command did not raise busy")
  `MCTW_ASSERT_SAME(a_read_in_scan, clk, rst, rd_vld, busy, "read data returned outside a scan")
  `MCTW_ASSERT_NEXT(a_done_follows, clk, rst, state == mctw_pkg::S_DONE, done && !busy,
                    "result strobe missing after scan")
  `MCTW_ASSERT_SAME(a_flags_excl, clk, rst, done, !(result.panic && result.refresh) &&
                    (!result.panic || (result.expired_count != '0)),
                    "panic and refresh inconsistent with count")

endmodule

FILE: bench/tb_multi_channel_task_watchdog_core.sv
// Self-checking testbench for the multi-channel task watchdog core.
module tb_multi_channel_task_watchdog_core;

  // Action codes that the block must ignore
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  localparam int SCAN_CYCLES = mctw_pkg::NUM_CHANNELS + 4;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 255;
  localparam int NUM_PHASES  = 6;
  localparam int MAX_REPORTS = 30;

  localparam mctw_pkg::result_t ALL_FRESH =
    '{expired_count: '0, panic: 1'b0, refresh: 1'b1};
  localparam mctw_pkg::result_t NONE_OVERDUE = '0;

  typedef struct {
    mctw_pkg::cmd_t    c;
    bit                typed;
    mctw_pkg::result_t want;
  } script_row_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  mctw_pkg::cmd_t                cmd;
  logic                          done;
  mctw_pkg::result_t             result;
  logic                          cfg_we;
  logic [mctw_pkg::TIME_W-1:0]   cfg_wdata;

  // Predicted channel table and timeout
  bit                            chan_on [mctw_pkg::NUM_CHANNELS];
  bit [mctw_pkg::TIME_W-1:0]     fed_at [mctw_pkg::NUM_CHANNELS];
  logic [mctw_pkg::TIME_W-1:0]   limit_ms = mctw_pkg::TIMEOUT_RESET;

  mctw_pkg::result_t             pending_reports [$];
  script_row_t                   script [$];
  int                            errors = 0;
  int                            quiet = 0;
  bit                            idle_mode = 1'b0;

  multi_channel_task_watchdog_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count active channels whose elapsed time, modulo 2^32, is past the timeout
  function automatic mctw_pkg::result_t tally_overdue(logic [mctw_pkg::TIME_W-1:0] now,
                                                      bit is_check);
    logic [mctw_pkg::CNT_W-1:0] n;
    mctw_pkg::result_t          r;
    n = '0;
    for (int i = 0; i < mctw_pkg::NUM_CHANNELS; i++) begin
      if (chan_on[i] && (mctw_pkg::TIME_W'(now - fed_at[i]) > limit_ms) &&
          n != mctw_pkg::CNT_MAX) n++;
    end
    r.expired_count = n;
    r.panic         = is_check && (n != 0);
    r.refresh       = is_check && (n == 0);
    return r;
  endfunction

  // Advance the channel table by one command
  task automatic apply_action(input mctw_pkg::cmd_t c, output bit has_report,
                              output mctw_pkg::result_t rep);
    bit in_range;
    in_range   = c.channel < mctw_pkg::NUM_CHANNELS;
    has_report = 1'b0;
    rep        = '0;
    case (c.action)
      mctw_pkg::ACT_CLEAR: begin
        for (int i = 0; i < mctw_pkg::NUM_CHANNELS; i++) begin
          chan_on[i] = 1'b0;
          fed_at[i]  = '0;
        end
      end
      mctw_pkg::ACT_START: begin
        if (in_range) begin
          fed_at[c.channel]  = c.now_ms;
          chan_on[c.channel] = 1'b1;
        end
      end
      mctw_pkg::ACT_FEED: begin
        if (in_range) fed_at[c.channel] = c.now_ms;
      end
      mctw_pkg::ACT_STOP: begin
        if (in_range) chan_on[c.channel] = 1'b0;
      end
      mctw_pkg::ACT_CHECK, mctw_pkg::ACT_BOOKKEEP: begin
        rep        = tally_overdue(c.now_ms, c.action == mctw_pkg::ACT_CHECK);
        has_report = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Offer one command, hold it until the transfer, then queue its report
  task automatic send_cmd(input mctw_pkg::cmd_t c, input bit typed,
                          input mctw_pkg::result_t want);
    bit                has_report;
    mctw_pkg::result_t rep;
    if (idle_mode && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_action(c, has_report, rep);
    if (has_report) pending_reports.push_back(typed ? want : rep);
  endtask

  // Write the timeout once the block has drained
  task automatic set_timeout(input logic [mctw_pkg::TIME_W-1:0] v);
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_ms = v;
  endtask

  task automatic add_row(input logic [2:0] act, input logic [2:0] ch,
                         input logic [mctw_pkg::TIME_W-1:0] t, input bit typed = 1'b0,
                         input mctw_pkg::result_t want = '0);
    script_row_t row;
    row.c.action  = act;
    row.c.channel = ch;
    row.c.now_ms  = t;
    row.typed     = typed;
    row.want      = want;
    script.push_back(row);
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    if (errors < MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    errors++;
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    mctw_pkg::result_t want;
    if (!rst && done) begin
      if (pending_reports.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual count %0d panic %0b refresh %0b",
                   $time, result.expired_count, result.panic, result.refresh);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (result.expired_count !== want.expired_count)
          note_mismatch("expired_count", want.expired_count, result.expired_count);
        if (result.panic !== want.panic)
          note_mismatch("panic", want.panic, result.panic);
        if (result.refresh !== want.refresh)
          note_mismatch("refresh", want.refresh, result.refresh);
      end
    end
  end

  // Stop the run if no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [mctw_pkg::TIME_W-1:0] t_ms;
    logic [mctw_pkg::TIME_W-1:0] span;
    logic [mctw_pkg::TIME_W-1:0] tmo_plan [NUM_PHASES];
    logic [2:0]                  act;
    mctw_pkg::cmd_t              c;
    int                          r;
    int                          made;

    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty table, boundary and wrap of elapsed time, spare codes
    add_row(mctw_pkg::ACT_CHECK, 3'd0, 32'd0, 1'b1, ALL_FRESH);
    add_row(mctw_pkg::ACT_BOOKKEEP, 3'd7, 32'hFFFF_FFFF, 1'b1, NONE_OVERDUE);
    add_row(mctw_pkg::ACT_START, 3'd0, 32'd0);
    add_row(mctw_pkg::ACT_START, 3'd7, 32'hFFFF_FFFF);
    add_row(mctw_pkg::ACT_CHECK, 3'd0, 32'd1000);
    add_row(mctw_pkg::ACT_CHECK, 3'd0, 32'd1001);
    add_row(mctw_pkg::ACT_FEED, 3'd0, 32'd1001);
    add_row(mctw_pkg::ACT_BOOKKEEP, 3'd0, 32'd1001);
    add_row(mctw_pkg::ACT_STOP, 3'd7, 32'd0);
    add_row(mctw_pkg::ACT_CHECK, 3'd5, 32'd2001);
    add_row(mctw_pkg::ACT_FEED, 3'd3, 32'd5);
    add_row(mctw_pkg::ACT_CHECK, 3'd3, 32'd5000);
    add_row(ACT_SPARE_6, 3'd5, 32'd9000);
    add_row(ACT_SPARE_7, 3'd2, 32'hA5A5_5A5A);
    for (int ch = 1; ch < 7; ch++) add_row(mctw_pkg::ACT_START, 3'(ch), 32'd100);
    // feed times later than now count as long overdue
    add_row(mctw_pkg::ACT_CHECK, 3'd0, 32'd50);
    add_row(mctw_pkg::ACT_BOOKKEEP, 3'd0, 32'd1100);
    add_row(mctw_pkg::ACT_CLEAR, 3'd4, 32'd7);
    add_row(mctw_pkg::ACT_CHECK, 3'd0, 32'hFFFF_FFFF, 1'b1, ALL_FRESH);
    foreach (script[i]) send_cmd(script[i].c, script[i].typed, script[i].want);

    // Random part: one timeout setting per phase, extremes included
    tmo_plan[0] = 32'd1;
    tmo_plan[1] = 32'hFFFF_FFFF;
    tmo_plan[2] = $urandom_range(2, 300);
    tmo_plan[3] = $urandom() | 32'd1;
    tmo_plan[4] = mctw_pkg::TIMEOUT_RESET;
    tmo_plan[5] = 32'd50;
    t_ms = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_timeout(tmo_plan[p]);
      span = (limit_ms >> 1) + 32'd2;
      if (span > 32'h00FF_FFFF) span = 32'h00FF_FFFF;
      idle_mode = (p != NUM_PHASES - 1);
      made = 0;
      while (made < PHASE_ITEMS) begin
        if ($urandom_range(0, 39) == 0)
          idle_mode = (p != NUM_PHASES - 1) && ($urandom_range(0, 1) == 1);
        // advance time, mostly by up to about half the timeout, sometimes by the timeout
        r = $urandom_range(0, 19);
        case (r)
          0:       t_ms = $urandom();
          1, 2:    t_ms = t_ms + limit_ms;
          3:       t_ms = t_ms + limit_ms + 32'd1;
          default: t_ms = t_ms + $urandom_range(0, span);
        endcase
        r = $urandom_range(0, 99);
        if (r < 3)       act = mctw_pkg::ACT_CLEAR;
        else if (r < 23) act = mctw_pkg::ACT_START;
        else if (r < 48) act = mctw_pkg::ACT_FEED;
        else if (r < 58) act = mctw_pkg::ACT_STOP;
        else if (r < 78) act = mctw_pkg::ACT_CHECK;
        else if (r < 93) act = mctw_pkg::ACT_BOOKKEEP;
        else             act = ($urandom_range(0, 1) == 1) ? ACT_SPARE_7 : ACT_SPARE_6;
        c.action  = act;
        c.channel = 3'($urandom_range(0, 7));
        c.now_ms  = t_ms;
        send_cmd(c, 1'b0, NONE_OVERDUE);
        made++;
      end
    end

    // Drain, then let the scan engine settle
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: multi_channel_task_watchdog_core.f
+incdir+rtl
rtl/mctw_pkg.sv
rtl/mctw_ram.sv
rtl/multi_channel_task_watchdog_core.sv
bench/tb_multi_channel_task_watchdog_core.sv
